/* src/assert_macros.svh */
// Assertion macros used by the depth sort top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("depth sort assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("depth sort assertion failed");

`endif

/* src/pdsort_pkg.sv */
// Package with the shared types and constants of the polygon depth sort.
package pdsort_pkg;

   // Width of an arrival index, fixed by the result word.
   localparam int INDEX_WIDTH = 6;

   // Control that the top level broadcasts to every cell of the row.
   typedef struct packed {
      logic load;    // insert the broadcast polygon into the sorted row
      logic drain;   // shift the row one place toward cell zero
   } cell_ctrl_type;

   typedef enum logic [0:0] {
      ST_LOAD = 1'b0,
      ST_EMIT = 1'b1
   } sort_state_type;

endpackage

/* src/polygon_depth_sort_unit.sv */
// Top level of the polygon depth sort: load control, insertion row and result port.
//
// Usage. A polygon word (three vertex z values, an enabled flag and a last
// mark) is taken at a rising edge where start is high and busy is low. The
// block takes one word per cycle, back to back, while it loads a set: the
// sum of the three z values is broadcast to a row of MAX_POLYS cells, and
// every cell either keeps its polygon, takes the new one or takes its left
// neighbor's, so the row stays sorted after each word.
// A word with the last mark ends the set: the edge that takes it raises
// busy, and the row drains through cell zero, one result word per cycle on
// rsp_* with rsp_valid high for exactly that cycle: first the enabled
// polygons in ascending key order (ties in arrival order), then the
// disabled ones in arrival order. A set of n polygons gives n results
// (at most MAX_POLYS); the state register turns busy first and the result
// registers then take cell zero. Busy falls in the cycle of the final
// result, so the next set can start while that result is still on the
// port. Words past MAX_POLYS are dropped and set rsp_overflowed on every
// result of the set. Results cannot be held off, so no stall path exists.
// Reset empties the row, the fill count and the overflow flag.
module polygon_depth_sort_unit
   import pdsort_pkg::*;
#(
   parameter int MAX_POLYS = 64,
   parameter int Z_WIDTH   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [Z_WIDTH-1:0]      req_vertex_z_a,
   input  logic [Z_WIDTH-1:0]      req_vertex_z_b,
   input  logic [Z_WIDTH-1:0]      req_vertex_z_c,
   input  logic                    req_poly_enabled,
   input  logic                    req_last_in,
   output logic                    rsp_valid,
   output logic [INDEX_WIDTH-1:0]  rsp_poly_index,
   output logic                    rsp_index_enabled,
   output logic                    rsp_overflowed,
   output logic                    rsp_last_out
);

`include "assert_macros.svh"

   localparam int KEY_WIDTH = Z_WIDTH + 2;
   localparam int CNT_WIDTH = $clog2(MAX_POLYS + 1);

   sort_state_type state_ff, state_in;

   logic [CNT_WIDTH-1:0] loaded_count_ff, loaded_count_in;
   logic [CNT_WIDTH-1:0] remaining_ff, remaining_in;
   logic                 overflow_ff, overflow_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_WIDTH-1:0] rsp_index_ff, rsp_index_in;
   logic                   rsp_en_ff, rsp_en_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                 accept;
   logic                 full;
   cell_ctrl_type        ctrl;

   logic signed [KEY_WIDTH-1:0] new_key;
   logic [INDEX_WIDTH-1:0]      new_index;

   logic signed [KEY_WIDTH-1:0] cell_key   [MAX_POLYS];
   logic [INDEX_WIDTH-1:0]      cell_index [MAX_POLYS];
   logic                        cell_en    [MAX_POLYS];
   logic                        cell_occ   [MAX_POLYS];
   logic                        cell_gt    [MAX_POLYS];

   assign busy   = (state_ff == ST_EMIT);
   assign accept = start && !busy;
   assign full   = (loaded_count_ff == CNT_WIDTH'(MAX_POLYS));

   // Sort key: sum of the three sign-extended z values; it always fits.
   assign new_key = {{2{req_vertex_z_a[Z_WIDTH-1]}}, req_vertex_z_a}
                  + {{2{req_vertex_z_b[Z_WIDTH-1]}}, req_vertex_z_b}
                  + {{2{req_vertex_z_c[Z_WIDTH-1]}}, req_vertex_z_c};
   assign new_index = INDEX_WIDTH'(loaded_count_ff);

   always_comb begin
      state_in        = state_ff;
      loaded_count_in = loaded_count_ff;
      remaining_in    = remaining_ff;
      overflow_in     = overflow_ff;
      ctrl            = '0;
      rsp_valid_in    = 1'b0;
      rsp_index_in    = cell_index[0];
      rsp_en_in       = cell_en[0];
      rsp_ovf_in      = overflow_ff;
      rsp_last_in     = (remaining_ff == CNT_WIDTH'(1));
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  ctrl.load       = 1'b1;
                  loaded_count_in = loaded_count_ff + CNT_WIDTH'(1);
               end
               if (req_last_in) begin
                  remaining_in = loaded_count_in;
                  state_in     = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            // Cell zero goes to the result register while the row shifts.
            ctrl.drain   = 1'b1;
            rsp_valid_in = 1'b1;
            remaining_in = remaining_ff - CNT_WIDTH'(1);
            if (remaining_ff == CNT_WIDTH'(1)) begin
               state_in        = ST_LOAD;
               loaded_count_in = '0;
               overflow_in     = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_en_ff    <= rsp_en_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
      remaining_ff <= remaining_in;
      if (reset) begin
         state_ff        <= ST_LOAD;
         loaded_count_ff <= '0;
         overflow_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         loaded_count_ff <= loaded_count_in;
         overflow_ff     <= overflow_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // The insertion row. Cell zero sees an occupied, never-greater left
   // neighbor; the last cell drains in an empty slot from the right.
   for (genvar i = 0; i < MAX_POLYS; i++) begin : g_row
      logic signed [KEY_WIDTH-1:0] p_key, n_key;
      logic [INDEX_WIDTH-1:0]      p_index, n_index;
      logic                        p_en, p_occ, p_gt, n_en, n_occ;

      if (i == 0) begin : g_first
         assign p_key   = new_key;
         assign p_index = new_index;
         assign p_en    = 1'b0;
         assign p_occ   = 1'b1;
         assign p_gt    = 1'b0;
      end else begin : g_inner
         assign p_key   = cell_key[i-1];
         assign p_index = cell_index[i-1];
         assign p_en    = cell_en[i-1];
         assign p_occ   = cell_occ[i-1];
         assign p_gt    = cell_gt[i-1];
      end

      if (i == MAX_POLYS - 1) begin : g_last
         assign n_key   = new_key;
         assign n_index = new_index;
         assign n_en    = 1'b0;
         assign n_occ   = 1'b0;
      end else begin : g_body
         assign n_key   = cell_key[i+1];
         assign n_index = cell_index[i+1];
         assign n_en    = cell_en[i+1];
         assign n_occ   = cell_occ[i+1];
      end

      pdsort_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_key    (new_key),
         .new_index  (new_index),
         .new_en     (req_poly_enabled),
         .prev_key   (p_key),
         .prev_index (p_index),
         .prev_en    (p_en),
         .prev_occ   (p_occ),
         .prev_gt    (p_gt),
         .next_key   (n_key),
         .next_index (n_index),
         .next_en    (n_en),
         .next_occ   (n_occ),
         .key        (cell_key[i]),
         .index      (cell_index[i]),
         .en         (cell_en[i]),
         .occ        (cell_occ[i]),
         .gt         (cell_gt[i])
      );
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_poly_index    = rsp_index_ff;
   assign rsp_index_enabled = rsp_en_ff;
   assign rsp_overflowed    = rsp_ovf_ff;
   assign rsp_last_out      = rsp_last_ff;

   // While draining, the head of the row always holds a polygon.
   `ASSERT_CLK(a_head_occupied, clock, reset, busy |-> cell_occ[0])
   // Draining begins only after a word with the last mark was taken.
   `ASSERT_CLK(a_emit_after_last, clock, reset, $rose(busy) |-> $past(accept && req_last_in))
   // The final result of a set is never followed directly by another one.
   `ASSERT_CLK(a_last_ends_set, clock, reset, (rsp_valid && rsp_last_out) |=> !rsp_valid)
   // The fill count never passes the capacity of the row.
   `ASSERT_CLK(a_count_bound, clock, reset, loaded_count_ff <= CNT_WIDTH'(MAX_POLYS))
   // A reset edge always leaves the result strobe low.
   `ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid)

endmodule

/* src/pdsort_cell.sv */
// One cell of the systolic insertion row: holds one polygon of the sorted set.
module pdsort_cell
   import pdsort_pkg::*;
#(
   parameter int KEY_WIDTH = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cell_ctrl_type                 ctrl,
   input  logic signed [KEY_WIDTH-1:0]   new_key,
   input  logic [INDEX_WIDTH-1:0]        new_index,
   input  logic                          new_en,
   input  logic signed [KEY_WIDTH-1:0]   prev_key,
   input  logic [INDEX_WIDTH-1:0]        prev_index,
   input  logic                          prev_en,
   input  logic                          prev_occ,
   input  logic                          prev_gt,
   input  logic signed [KEY_WIDTH-1:0]   next_key,
   input  logic [INDEX_WIDTH-1:0]        next_index,
   input  logic                          next_en,
   input  logic                          next_occ,
   output logic signed [KEY_WIDTH-1:0]   key,
   output logic [INDEX_WIDTH-1:0]        index,
   output logic                          en,
   output logic                          occ,
   output logic                          gt
);

   logic signed [KEY_WIDTH-1:0] key_ff, key_in;
   logic [INDEX_WIDTH-1:0]      index_ff, index_in;
   logic                        en_ff, en_in;
   logic                        occ_ff, occ_in;

   // The stored polygon sorts after the new one. Enabled polygons come first
   // in key order; disabled ones follow in arrival order, so a new polygon
   // never passes an equal or disabled one that arrived earlier.
   assign gt = occ_ff && new_en && (!en_ff || (key_ff > new_key));

   always_comb begin
      key_in   = key_ff;
      index_in = index_ff;
      en_in    = en_ff;
      occ_in   = occ_ff;
      if (ctrl.drain) begin
         key_in   = next_key;
         index_in = next_index;
         en_in    = next_en;
         occ_in   = next_occ;
      end else if (ctrl.load) begin
         if (prev_gt) begin
            key_in   = prev_key;
            index_in = prev_index;
            en_in    = prev_en;
            occ_in   = prev_occ;
         end else if (gt || (!occ_ff && prev_occ)) begin
            key_in   = new_key;
            index_in = new_index;
            en_in    = new_en;
            occ_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      index_ff <= index_in;
      en_ff    <= en_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign key   = key_ff;
   assign index = index_ff;
   assign en    = en_ff;
   assign occ   = occ_ff;

endmodule

/* sim/tb_polygon_depth_sort_unit.sv */
// Self-checking testbench for the polygon depth sort unit: random and directed polygon sets.
`timescale 1ns / 100ps

module tb_polygon_depth_sort_unit
   import pdsort_pkg::*;
();

   localparam int MAX_POLYS    = 64;
   localparam int Z_WIDTH      = 16;
   localparam int KEY_WIDTH    = Z_WIDTH + 2;
   // Enough for one pass of the longest pipeline after the last result.
   localparam int DRAIN_SLACK  = 8;
   localparam int RANDOM_ITEMS = 200;

   // One expected result word of the emitted order.
   typedef struct packed {
      logic [INDEX_WIDTH-1:0] poly_index;
      logic                   index_enabled;
      logic                   overflowed;
      logic                   last_out;
   } depth_entry_type;

   // How the vertex z values of a random polygon are spread.
   typedef enum int {
      Z_FULL,      // anywhere in the signed range
      Z_NARROW,    // a few values around zero, so that keys often tie
      Z_EXTREME,   // corners of the range
      Z_MIXED      // each vertex picks one of the spreads above
   } z_spread_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [Z_WIDTH-1:0]     req_vertex_z_a;
   logic [Z_WIDTH-1:0]     req_vertex_z_b;
   logic [Z_WIDTH-1:0]     req_vertex_z_c;
   logic                   req_poly_enabled;
   logic                   req_last_in;
   logic                   rsp_valid;
   logic [INDEX_WIDTH-1:0] rsp_poly_index;
   logic                   rsp_index_enabled;
   logic                   rsp_overflowed;
   logic                   rsp_last_out;

   // Our own copy of what the block holds for the set being loaded.
   logic signed [KEY_WIDTH-1:0] held_key [MAX_POLYS];
   logic                        held_enabled [MAX_POLYS];
   int                          held_count;
   logic                        held_overflow;

   // Result words that the block still owes, oldest first.
   depth_entry_type depth_order_q[$];

   int  mismatch_count;
   int  random_items;
   // Sender pacing: when on, words go out in bursts with idle gaps between them.
   bit  pacing_on;
   int  burst_left;

   polygon_depth_sort_unit #(
      .MAX_POLYS (MAX_POLYS),
      .Z_WIDTH   (Z_WIDTH)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_vertex_z_a    (req_vertex_z_a),
      .req_vertex_z_b    (req_vertex_z_b),
      .req_vertex_z_c    (req_vertex_z_c),
      .req_poly_enabled  (req_poly_enabled),
      .req_last_in       (req_last_in),
      .rsp_valid         (rsp_valid),
      .rsp_poly_index    (rsp_poly_index),
      .rsp_index_enabled (rsp_index_enabled),
      .rsp_overflowed    (rsp_overflowed),
      .rsp_last_out      (rsp_last_out)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   // Predictor. Every accepted word goes through here. A word past capacity
   // is dropped and marks the set as overflowed, but its last mark still
   // closes the set. On the close, the enabled polygons are ordered by key
   // with a stable insertion, so equal keys stay in arrival order, and the
   // disabled ones follow in arrival order.
   function automatic void absorb_polygon(input logic [Z_WIDTH-1:0] za,
                                          input logic [Z_WIDTH-1:0] zb,
                                          input logic [Z_WIDTH-1:0] zc,
                                          input logic en, input logic last);
      logic signed [KEY_WIDTH-1:0] key;
      int                          order[$];
      int                          pos;
      depth_entry_type             entry;

      // The sum of three sign-extended z values always fits in two extra bits.
      key = KEY_WIDTH'($signed(za)) + KEY_WIDTH'($signed(zb)) + KEY_WIDTH'($signed(zc));
      if (held_count < MAX_POLYS) begin
         held_key[held_count]     = key;
         held_enabled[held_count] = en;
         held_count++;
      end else begin
         held_overflow = 1'b1;
      end
      if (!last) begin
         return;
      end

      for (int i = 0; i < held_count; i++) begin
         if (held_enabled[i]) begin
            pos = order.size();
            while (pos > 0 && held_key[order[pos - 1]] > held_key[i]) begin
               pos--;
            end
            order.insert(pos, i);
         end
      end
      for (int i = 0; i < held_count; i++) begin
         if (!held_enabled[i]) begin
            order.push_back(i);
         end
      end
      for (int k = 0; k < order.size(); k++) begin
         entry.poly_index    = INDEX_WIDTH'(order[k]);
         entry.index_enabled = held_enabled[order[k]];
         entry.overflowed    = held_overflow;
         entry.last_out      = (k == order.size() - 1);
         depth_order_q.push_back(entry);
      end
      held_count    = 0;
      held_overflow = 1'b0;
   endfunction

   // Results cannot be held off, so every strobe is a result taken at this
   // edge. Outputs are read before the block's own updates of the edge land.
   always @(posedge clock) begin
      depth_entry_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (depth_order_q.size() == 0) begin
            report_mismatch($sformatf("result for polygon %0d with none outstanding",
                                      rsp_poly_index));
         end else begin
            want = depth_order_q.pop_front();
            check_field("poly_index", rsp_poly_index, want.poly_index);
            check_field("index_enabled", rsp_index_enabled, want.index_enabled);
            check_field("overflowed", rsp_overflowed, want.overflowed);
            check_field("last_out", rsp_last_out, want.last_out);
         end
      end
   end

   // An idle stretch of the sender. The request fields carry junk while start
   // is low, which the block must ignore.
   task automatic idle_gap();
      start            <= 1'b0;
      req_vertex_z_a   <= Z_WIDTH'($urandom);
      req_vertex_z_b   <= Z_WIDTH'($urandom);
      req_vertex_z_c   <= Z_WIDTH'($urandom);
      req_poly_enabled <= 1'($urandom);
      req_last_in      <= 1'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clock);
      burst_left = $urandom_range(1, 12);
   endtask

   // Sends one polygon word and waits for the edge that takes it. Start stays
   // high into the next word unless a gap follows. After the last word of a
   // set, start drops and the sender waits until the block has turned busy
   // (or already sent its final result) before it offers the next word, so
   // no word is offered in the cycle before busy rises.
   task automatic send_polygon(input logic [Z_WIDTH-1:0] za,
                               input logic [Z_WIDTH-1:0] zb,
                               input logic [Z_WIDTH-1:0] zc,
                               input logic en, input logic last);
      start            <= 1'b1;
      req_vertex_z_a   <= za;
      req_vertex_z_b   <= zb;
      req_vertex_z_c   <= zc;
      req_poly_enabled <= en;
      req_last_in      <= last;
      do @(posedge clock); while (busy !== 1'b0);
      absorb_polygon(za, zb, zc, en, last);

      if (last) begin
         start <= 1'b0;
         do @(posedge clock);
         while (!(busy === 1'b1 || (rsp_valid === 1'b1 && rsp_last_out === 1'b1)));
      end
      if (pacing_on) begin
         burst_left--;
         if (burst_left <= 0) begin
            idle_gap();
         end
      end
   endtask

   function automatic logic [Z_WIDTH-1:0] pick_z(input z_spread_type spread);
      logic [Z_WIDTH-1:0] z;
      case (spread)
         Z_FULL: begin
            z = Z_WIDTH'($urandom);
         end
         Z_NARROW: begin
            z = Z_WIDTH'($urandom_range(0, 6) - 3);
         end
         Z_EXTREME: begin
            case ($urandom_range(0, 4))
               0: z = {1'b0, {(Z_WIDTH - 1){1'b1}}};
               1: z = {1'b1, {(Z_WIDTH - 1){1'b0}}};
               2: z = '0;
               3: z = '1;
               default: z = Z_WIDTH'(1);
            endcase
         end
         default: begin
            z = pick_z(z_spread_type'($urandom_range(0, 2)));
         end
      endcase
      return z;
   endfunction

   // One set of random polygons; the last word always carries the mark.
   task automatic send_random_set(input int size, input z_spread_type spread,
                                  input int enable_pct);
      for (int i = 0; i < size; i++) begin
         send_polygon(pick_z(spread), pick_z(spread), pick_z(spread),
                      $urandom_range(1, 100) <= enable_pct, i == size - 1);
      end
   endtask

   // Sets of one polygon: the largest and smallest keys, and a set that holds
   // only a disabled polygon.
   task automatic test_single_polygons();
      pacing_on = 1'b0;
      send_polygon(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
      send_polygon(16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1);
      send_polygon(16'h0000, 16'hFFFF, 16'h0001, 1'b0, 1'b1);
   endtask

   // Mixed sets: extreme keys, keys that tie in different ways, alternating
   // bit patterns, disabled polygons spread through the set, and a close on
   // a disabled polygon as well as on an enabled one.
   task automatic test_mixed_sets();
      pacing_on  = 1'b1;
      burst_left = 3;
      send_polygon(16'h0005, 16'h0000, 16'h0000, 1'b1, 1'b0);
      send_polygon(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
      send_polygon(16'h0002, 16'h0002, 16'h0001, 1'b1, 1'b0);   // ties with the first
      send_polygon(16'h1234, 16'h8000, 16'h0000, 1'b0, 1'b0);
      send_polygon(16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0);
      send_polygon(16'h5555, 16'hAAAA, 16'h0000, 1'b1, 1'b0);   // sums to -1
      send_polygon(16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b0);   // ties with the one above
      send_polygon(16'h0000, 16'h0000, 16'h0005, 1'b1, 1'b0);   // third polygon with key 5
      send_polygon(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 1'b1);
      send_polygon(16'h0001, 16'h0001, 16'h0001, 1'b0, 1'b0);
      send_polygon(16'h7FFF, 16'h8000, 16'h0003, 1'b1, 1'b0);
      send_polygon(16'h0003, 16'h7FFF, 16'h8000, 1'b1, 1'b0);   // same key, reordered vertices
      send_polygon(16'hFFFE, 16'hFFFE, 16'hFFFE, 1'b1, 1'b1);
   endtask

   // Capacity: a set that exactly fills the row, one whose closing word is
   // the first dropped one, and one that overruns by several words.
   task automatic test_capacity();
      pacing_on  = 1'b1;
      burst_left = $urandom_range(1, 12);
      send_random_set(MAX_POLYS, Z_NARROW, 70);
      send_random_set(MAX_POLYS + 1, Z_MIXED, 60);
      pacing_on = 1'b0;
      send_random_set(MAX_POLYS + 3, Z_FULL, 80);
   endtask

   // Random sets. Most are small so that many sets close; a few are large or
   // run past capacity. Each set picks its own spread, enable mix and pacing.
   task automatic test_random_sets();
      int           size;
      z_spread_type spread;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0:       size = $urandom_range(MAX_POLYS - 4, MAX_POLYS + 4);
            1, 2:    size = $urandom_range(11, 40);
            default: size = $urandom_range(1, 10);
         endcase
         spread     = z_spread_type'($urandom_range(0, 3));
         pacing_on  = ($urandom_range(0, 9) < 7);
         burst_left = $urandom_range(1, 12);
         send_random_set(size, spread, $urandom_range(0, 4) * 25);
         random_items += size;
      end
   endtask

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_vertex_z_a   <= '0;
      req_vertex_z_b   <= '0;
      req_vertex_z_c   <= '0;
      req_poly_enabled <= 1'b0;
      req_last_in      <= 1'b0;
      mismatch_count    = 0;
      random_items      = 0;
      held_count        = 0;
      held_overflow     = 1'b0;
      pacing_on         = 1'b0;
      burst_left        = 1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_polygons();
      test_mixed_sets();
      test_capacity();
      test_random_sets();

      // Every set ends on a marked word, so all results are owed by now.
      while (depth_order_q.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_polygon_depth_sort_unit passed");
      end else begin
         $display("tb_polygon_depth_sort_unit failed");
      end
      $finish;
   end

   // A correct run takes well under a tenth of this.
   initial begin
      #2_000_000;
      $display("tb_polygon_depth_sort_unit failed");
      $finish;
   end

endmodule
